@@ rtl/core/mtdr_pkg.sv @@
package mtdr_pkg;

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int MIX_W       = 32;
    localparam int DELAY_W     = 12;
    localparam int GAIN_W      = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // tap bookkeeping
    localparam int NUM_TAPS_MAX = 4;
    localparam int TAP_IDX_W    = 2;

    // gain times sample, signed, and its magnitude
    localparam int PROD_W = GAIN_W + 1 + SAMPLE_W;
    localparam int MAG_W  = 32;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_TAP0_DELAY = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP1_DELAY = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP2_DELAY = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP3_DELAY = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP0_GAIN  = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP1_GAIN  = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP2_GAIN  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP3_GAIN  = 4'd7;

    typedef struct packed {
        logic                 start_item;
        logic                 rd_en;
        logic                 mul_en;
        logic                 div_start;
        logic                 acc_en;
        logic                 load_out;
        logic [TAP_IDX_W-1:0] tap;
    } mtdr_cmd_t;

    typedef struct packed {
        logic div_done;
    } mtdr_status_t;

endpackage

@@ rtl/core/mtdr_if.sv @@
interface mtdr_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mtdr_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface mtdr_mix_if;
    logic                               valid;
    logic                               ready;
    logic signed [mtdr_pkg::MIX_W-1:0] mix_out;

    modport source (output valid, output mix_out, input ready);
    modport sink   (input valid, input mix_out, output ready);
endinterface

interface mtdr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mtdr_pkg::CFG_INDEX_W-1:0]  index;
    logic [mtdr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/mtdr_ram.sv @@
module mtdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/mtdr_divider.sv @@
module mtdr_divider #(
    parameter int unsigned DIVISOR = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mtdr_pkg::MAG_W-1:0] dividend,
    output logic                       done,
    output logic [mtdr_pkg::MAG_W-1:0] quotient
);
    import mtdr_pkg::*;

    // scaled reciprocal of the divisor, exact for any dividend below 2^MAG_W
    localparam int unsigned     PRE_SHIFT = $clog2(DIVISOR);
    localparam int unsigned     SHIFT     = MAG_W + PRE_SHIFT;
    localparam longint unsigned SCALE     = 64'd1 << SHIFT;
    localparam longint unsigned RECIP_L   = (SCALE + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MAG_W:0]  RECIP     = (MAG_W+1)'(RECIP_L);
    localparam int              PROD_LEN  = 2 * MAG_W + 1;

    logic [PROD_LEN-1:0] prod_reg, prod_next;
    logic                done_reg, done_next;

    // one multiply by the reciprocal, the shift is wiring
    assign prod_next = {{(MAG_W+1){1'b0}}, dividend} * {{MAG_W{1'b0}}, RECIP};
    assign done_next = start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod_next;
        end
    end

    assign done     = done_reg;
    assign quotient = MAG_W'(prod_reg >> SHIFT);

endmodule

@@ rtl/core/mtdr_datapath.sv @@
module mtdr_datapath #(
    parameter int unsigned DELAY_DEPTH = 4096,
    parameter int unsigned GAIN_UNITY  = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mtdr_pkg::mtdr_cmd_t                   cmd,
    output mtdr_pkg::mtdr_status_t                status,
    input  logic signed [mtdr_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                  cfg_we,
    input  logic [mtdr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mtdr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [mtdr_pkg::MIX_W-1:0]    mix_out
);
    import mtdr_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int CW = $clog2(DELAY_DEPTH + 1);
    localparam logic [16:0] MAX_DELAY = 17'(DELAY_DEPTH - 1);
    localparam logic [17:0] DEPTH_X   = 18'(DELAY_DEPTH);

    logic [DELAY_W-1:0] delay_reg [NUM_TAPS_MAX];
    logic [GAIN_W-1:0]  gain_reg  [NUM_TAPS_MAX];

    logic [AW-1:0]      wi_reg, wi_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic               rd_ok_reg;
    logic               neg_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [MIX_W-1:0]   acc_reg;
    logic [MIX_W-1:0]   mix_reg;

    logic [16:0]        d_ext, d_clamp;
    logic [17:0]        pos_sum, pos_wrap;
    logic [AW-1:0]      rd_addr;
    logic               rd_valid;
    logic [SAMPLE_W-1:0] rd_data;

    logic signed [SAMPLE_W-1:0] s_sel;
    logic signed [GAIN_W:0]     g_s;
    logic signed [PROD_W-1:0]   prod, prod_neg;
    logic [MAG_W-1:0]           mag_v;
    logic [MAG_W-1:0]           quotient;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TAPS_MAX; t++)
            begin
                delay_reg[t] <= '0;
                gain_reg[t]  <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TAP0_DELAY: delay_reg[0] <= cfg_data[DELAY_W-1:0];
                REG_TAP1_DELAY: delay_reg[1] <= cfg_data[DELAY_W-1:0];
                REG_TAP2_DELAY: delay_reg[2] <= cfg_data[DELAY_W-1:0];
                REG_TAP3_DELAY: delay_reg[3] <= cfg_data[DELAY_W-1:0];
                REG_TAP0_GAIN:  gain_reg[0]  <= cfg_data[GAIN_W-1:0];
                REG_TAP1_GAIN:  gain_reg[1]  <= cfg_data[GAIN_W-1:0];
                REG_TAP2_GAIN:  gain_reg[2]  <= cfg_data[GAIN_W-1:0];
                REG_TAP3_GAIN:  gain_reg[3]  <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // tap address: clamp the delay, step back from the write index
    always_comb
    begin
        d_ext    = 17'(delay_reg[cmd.tap]);
        d_clamp  = (d_ext > MAX_DELAY) ? MAX_DELAY : d_ext;
        pos_sum  = 18'(wi_reg) + DEPTH_X - 18'(d_clamp);
        pos_wrap = (pos_sum >= DEPTH_X) ? (pos_sum - DEPTH_X) : pos_sum;
        rd_addr  = pos_wrap[AW-1:0];
        // history older than the fill count reads as zero
        rd_valid = (d_clamp <= 17'(fill_reg));
    end

    mtdr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.start_item),
        .waddr (wi_reg),
        .wdata (sample_in),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // gain times sample, split into sign and magnitude
    always_comb
    begin
        s_sel    = rd_ok_reg ? $signed(rd_data) : '0;
        g_s      = $signed({1'b0, gain_reg[cmd.tap]});
        prod     = g_s * s_sel;
        prod_neg = -prod;
        mag_v    = prod[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod[MAG_W-1:0];
    end

    mtdr_divider #(
        .DIVISOR (GAIN_UNITY)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mag_reg),
        .done     (status.div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_ok_reg <= rd_valid;
        end
        if (cmd.mul_en)
        begin
            mag_reg <= mag_v;
            neg_reg <= prod[PROD_W-1];
        end
        if (cmd.start_item)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= neg_reg ? (acc_reg - quotient) : (acc_reg + quotient);
        end
        if (cmd.load_out)
        begin
            mix_reg <= acc_reg;
        end
    end

    // write index and fill count advance once the item is done
    always_comb
    begin
        wi_next   = wi_reg;
        fill_next = fill_reg;
        if (cmd.load_out)
        begin
            wi_next = (wi_reg == AW'(DELAY_DEPTH - 1)) ? '0 : (wi_reg + AW'(1));
            if (fill_reg != CW'(DELAY_DEPTH))
            begin
                fill_next = fill_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wi_reg   <= wi_next;
            fill_reg <= fill_next;
        end
    end

    assign mix_out = $signed(mix_reg);

endmodule

@@ rtl/core/mtdr_ctrl.sv @@
module mtdr_ctrl #(
    parameter int unsigned TAP_COUNT = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mtdr_pkg::mtdr_cmd_t    cmd,
    input  mtdr_pkg::mtdr_status_t status
);
    import mtdr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIVGO = 3'd3;
    localparam logic [2:0] ST_DIVW  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(TAP_COUNT - 1);

    logic [2:0]           state_reg, state_next;
    logic [TAP_IDX_W-1:0] tap_reg, tap_next;
    logic                 out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        tap_next       = tap_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.tap        = tap_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start_item = 1'b1;
                    tap_next       = '0;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (status.div_done)
                begin
                    cmd.acc_en = 1'b1;
                    if (tap_reg == LAST_TAP)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        tap_next   = tap_reg + TAP_IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/multi_tap_delay_reverb_unit.sv @@
// channel  | dir | payload              | accepted when
// ---------+-----+----------------------+----------------------------
// src      | in  | sample_in   s16      | src.valid && src.ready
// dst      | out | mix_out     s32      | dst.valid && dst.ready
// cfg      | in  | index u4, data u16   | cfg.valid && cfg.ready
//
// an item is accepted, then per tap the block does a store read, a multiply,
// a reciprocal multiply and an accumulate, and at the end it loads the
// output register
// no clearing pass: a fill count masks store entries not yet written
// src.ready is high only between items; a stalled dst holds the result in
// its output register while the next item is already accepted and worked on
// cfg.ready is always high; write registers only while the block is idle
module multi_tap_delay_reverb_unit #(
    parameter int unsigned DELAY_DEPTH = 4096,
    parameter int unsigned TAP_COUNT   = 4,
    parameter int unsigned GAIN_UNITY  = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    mtdr_sample_if.sink    src,
    mtdr_mix_if.source     dst,
    mtdr_cfg_if.sink       cfg
);
    import mtdr_pkg::*;

    // command and status between sequencer and datapath
    mtdr_cmd_t    cmd;
    mtdr_status_t status;

    // sequencer: one item at a time, taps in turn
    mtdr_ctrl #(
        .TAP_COUNT (TAP_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (src.valid),
        .in_ready  (src.ready),
        .out_valid (dst.valid),
        .out_ready (dst.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath: registers, delay store, multiplier, divider, accumulator
    mtdr_datapath #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .GAIN_UNITY  (GAIN_UNITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample_in (src.sample_in),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .mix_out   (dst.mix_out)
    );

    // register writes never stall
    assign cfg.ready = 1'b1;

endmodule

@@ rtl/core/mtdr_checker.sv @@
module mtdr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                src_valid,
    input logic                                src_ready,
    input logic                                dst_valid,
    input logic                                dst_ready,
    input logic signed [mtdr_pkg::MIX_W-1:0]  mix_out,
    input logic                                cfg_ready
);

    // a waiting result is not withdrawn
    assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_ready) |=> dst_valid)
        else $error("result dropped while stalled");

    // a waiting result does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_ready) |=> $stable(mix_out))
        else $error("result changed while stalled");

    // items are worked one at a time, so no item follows in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && src_ready) |=> !src_ready)
        else $error("input taken back to back");

    // a result never appears right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && src_ready) |=> !$rose(dst_valid))
        else $error("result too early");

    // register writes are always taken
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port stalled");

endmodule

bind multi_tap_delay_reverb_unit mtdr_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src.valid),
    .src_ready (src.ready),
    .dst_valid (dst.valid),
    .dst_ready (dst.ready),
    .mix_out   (dst.mix_out),
    .cfg_ready (cfg.ready)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import mtdr_pkg::*;

    // block configuration, kept in step with the instance below
    localparam int unsigned DEPTH = 4096;
    localparam int unsigned TAPS  = 4;
    localparam int unsigned UNITY = 4096;

    // register indexes past the tap map, which the block ignores
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_REG = REG_TAP3_GAIN + CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] LAST_REG         = {CFG_INDEX_W{1'b1}};

    // random part: several tap settings, one block of samples each
    localparam int SETTINGS_COUNT   = 8;
    localparam int ITEMS_PER_SETTING = 180;

    // longer than one item takes, so this covers the drain
    localparam int DRAIN_CYCLES = 4 * TAPS + 12;

    // mirror of the echo line: history, write pointer, tap registers and
    // the queue of mixes still owed by the block
    class echo_mix_tracker;
        logic signed [SAMPLE_W-1:0] history [DEPTH];
        int unsigned                wr_pos;
        logic [DELAY_W-1:0]         tap_delay [NUM_TAPS_MAX];
        logic [GAIN_W-1:0]          tap_gain [NUM_TAPS_MAX];
        logic signed [MIX_W-1:0]    pending_mix [$];
        int                         samples_taken;
        int                         mixes_checked;
        int                         failures;

        function new();
            foreach (history[i])
                history[i] = '0;
            foreach (tap_delay[i])
            begin
                tap_delay[i] = '0;
                tap_gain[i]  = '0;
            end
            wr_pos        = 0;
            samples_taken = 0;
            mixes_checked = 0;
            failures      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx >= REG_TAP0_DELAY && idx <= REG_TAP3_DELAY)
                tap_delay[idx - REG_TAP0_DELAY] = data[DELAY_W-1:0];
            else if (idx >= REG_TAP0_GAIN && idx <= REG_TAP3_GAIN)
                tap_gain[idx - REG_TAP0_GAIN] = data[GAIN_W-1:0];
        endfunction

        // store the sample, then sum gain * history / unity over the taps
        function void take_sample(logic signed [SAMPLE_W-1:0] s);
            int unsigned             d;
            int unsigned             pos;
            longint                  g;
            longint                  v;
            longint                  q;
            logic signed [MIX_W-1:0] mix;
            mix = '0;
            history[wr_pos] = s;
            for (int t = 0; t < TAPS; t++)
            begin
                d = tap_delay[t];
                if (d > DEPTH - 1)
                    d = DEPTH - 1;
                pos = (wr_pos + DEPTH - d) % DEPTH;
                g = tap_gain[t];
                v = history[pos];
                // longint division truncates toward zero
                q = (g * v) / longint'(UNITY);
                mix = mix + q[MIX_W-1:0];
            end
            wr_pos = (wr_pos + 1) % DEPTH;
            pending_mix.push_back(mix);
            samples_taken++;
        endfunction

        function void check_mix(logic signed [MIX_W-1:0] got);
            logic signed [MIX_W-1:0] want;
            if (pending_mix.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("mix %0d arrived with none outstanding", got);
                return;
            end
            want = pending_mix.pop_front();
            mixes_checked++;
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display("mix %0d wrong: expected %0d, got %0d",
                             mixes_checked, want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mtdr_sample_if sample_ch ();
    mtdr_mix_if    mix_ch ();
    mtdr_cfg_if    cfg_ch ();

    multi_tap_delay_reverb_unit #(
        .DELAY_DEPTH (DEPTH),
        .TAP_COUNT   (TAPS),
        .GAIN_UNITY  (UNITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (sample_ch),
        .dst   (mix_ch),
        .cfg   (cfg_ch)
    );

    echo_mix_tracker tracker;

    // when set, neither side inserts gaps or stalls
    bit no_idle;
    int settings_used;

    // extremes and values around the unity gain boundary
    logic signed [SAMPLE_W-1:0] corner_samples [12] = '{
        16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh8000,
        16'sh7FFF, 16'sh7FFF, -16'sd4095, 16'sd4095, -16'sd4096, 16'sd4096
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // register write; the channel always drops valid for one cycle after
    // the item so back-to-back writes never double-drive valid in one step
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        tracker.write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // one sample item; valid stays high between back-to-back items and is
    // only lowered when a gap is drawn or the mixes are drained
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample_in <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        tracker.take_sample(s);
    endtask

    // drop valid and wait until every owed mix has come back, so the
    // block is idle before the registers change
    task automatic drain_mixes();
        sample_ch.valid <= 1'b0;
        while (tracker.pending_mix.size() != 0)
            @(posedge clk);
    endtask

    // random tap setting: delays often short so history is actually hit,
    // else at the extremes or random; delay writes carry junk in upper bits
    // to exercise masking; gains at zero, full scale, unity or random
    task automatic program_taps();
        logic [DELAY_W-1:0]    d;
        logic [GAIN_W-1:0]     g;
        logic [CFG_DATA_W-1:0] junk;
        for (int t = 0; t < NUM_TAPS_MAX; t++)
        begin
            case ($urandom_range(0, 3))
                0:       d = $urandom_range(0, 1) ? '0 : '1;
                1, 2:    d = DELAY_W'($urandom_range(0, 200));
                default: d = DELAY_W'($urandom);
            endcase
            junk = CFG_DATA_W'($urandom);
            cfg_write(REG_TAP0_DELAY + CFG_INDEX_W'(t), {junk[CFG_DATA_W-1:DELAY_W], d});
            case ($urandom_range(0, 3))
                0:       g = $urandom_range(0, 1) ? '0 : '1;
                1:       g = GAIN_W'(UNITY);
                default: g = GAIN_W'($urandom);
            endcase
            cfg_write(REG_TAP0_GAIN + CFG_INDEX_W'(t), g);
        end
        // a stray write outside the map must leave the taps alone
        if ($urandom_range(0, 1))
            cfg_write(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG)),
                      CFG_DATA_W'($urandom));
        settings_used++;
    endtask

    // result side: random stall before each item, then hold ready until
    // the block hands one over
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                mix_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            mix_ch.ready <= 1'b1;
            @(posedge clk);
            while (!mix_ch.valid)
                @(posedge clk);
            tracker.check_mix(mix_ch.mix_out);
        end
    end

    // hard stop well past the slowest legal run (about 1460 items plus
    // register writes)
    initial
    begin
        #(5_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        logic signed [SAMPLE_W-1:0] s;
        tracker = new();
        no_idle = 1'b0;
        settings_used = 0;

        rst_n               = 1'b0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample_in = '0;
        mix_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: all gains zero, mix must be zero
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        drain_mixes();

        // tap 0 passes the current sample at unity, tap 1 the previous one
        // at full gain, tap 2 reaches back into history never written,
        // tap 3 gets a wide value that masks down to a short delay and a
        // tiny gain so small negatives truncate to zero
        cfg_write(REG_TAP0_DELAY, '0);
        cfg_write(REG_TAP0_GAIN, CFG_DATA_W'(UNITY));
        cfg_write(REG_TAP1_DELAY, 16'd1);
        cfg_write(REG_TAP1_GAIN, '1);
        cfg_write(REG_TAP2_DELAY, {{(CFG_DATA_W-DELAY_W){1'b0}}, {DELAY_W{1'b1}}});
        cfg_write(REG_TAP2_GAIN, '1);
        cfg_write(REG_TAP3_DELAY, 16'hF003);
        cfg_write(REG_TAP3_GAIN, 16'd1);
        // writes off the end of the map are dropped
        cfg_write(FIRST_UNUSED_REG, '1);
        cfg_write(LAST_REG, 16'h1234);
        settings_used++;
        foreach (corner_samples[i])
            send_sample(corner_samples[i]);
        drain_mixes();

        // every tap on the current sample at full gain: largest mix magnitude
        for (int t = 0; t < NUM_TAPS_MAX; t++)
        begin
            cfg_write(REG_TAP0_DELAY + CFG_INDEX_W'(t), '0);
            cfg_write(REG_TAP0_GAIN + CFG_INDEX_W'(t), '1);
        end
        settings_used++;
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'shFFFF);
        drain_mixes();

        // random part, one tap setting per block; two blocks run without
        // any gaps or stalls
        for (int ph = 0; ph < SETTINGS_COUNT; ph++)
        begin
            program_taps();
            no_idle = (ph == 2 || ph == 5);
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       s = 16'sh8000;
                        1:       s = 16'sh7FFF;
                        2:       s = 16'sh0000;
                        default: s = 16'shFFFF;
                    endcase
                end
                else
                    s = SAMPLE_W'($urandom);
                send_sample(s);
            end
            drain_mixes();
            no_idle = 1'b0;
        end

        // let any stray late result show up before judging
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending_mix.size() != 0)
        begin
            $display("%0d mixes never arrived", tracker.pending_mix.size());
            tracker.failures += tracker.pending_mix.size();
        end

        $display("sent %0d samples over %0d tap settings, compared %0d mixes",
                 tracker.samples_taken, settings_used, tracker.mixes_checked);
        $display("failures: %0d", tracker.failures);
        if (tracker.failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mtdr_pkg.sv
rtl/core/mtdr_if.sv
rtl/core/mtdr_ram.sv
rtl/core/mtdr_divider.sv
rtl/core/mtdr_datapath.sv
rtl/core/mtdr_ctrl.sv
rtl/core/multi_tap_delay_reverb_unit.sv
rtl/core/mtdr_checker.sv
tb/testbench.sv
